// ----- rtl/core/oled_command_stream_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the OLED command stream decoder
// Concurrent checks clocked by clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef OLED_COMMAND_STREAM_DECODER_ASSERT_SVH
`define OLED_COMMAND_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTH
`define OCSD_ASSERT_SAME(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);
`define OCSD_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);
`else
`define OCSD_ASSERT_SAME(lbl, ant, cons, msg)
`define OCSD_ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

// ----- rtl/core/ocsd_pkg.sv -----
// ----------------------------------------------------------------------------
// OLED command stream decoder package
// Command codes, parameter counts and the types shared by the decoder.
// ----------------------------------------------------------------------------
package ocsd_pkg;

	localparam int DEF_COLUMNS    = 120;
	localparam int DEF_ROWS       = 128;
	localparam int DEF_MAX_PARAMS = 15;

	localparam int PARAM_CNT_W = 5;

	localparam logic [7:0] OP_GRAY_ENABLE  = 8'h00;
	localparam logic [7:0] OP_COLUMN       = 8'h15;
	localparam logic [7:0] OP_WRITE_RAM    = 8'h5C;
	localparam logic [7:0] OP_ROW          = 8'h75;
	localparam logic [7:0] OP_REMAP        = 8'hA0;
	localparam logic [7:0] OP_START_LINE   = 8'hA1;
	localparam logic [7:0] OP_OFFSET       = 8'hA2;
	localparam logic [7:0] OP_ALL_OFF      = 8'hA4;
	localparam logic [7:0] OP_ALL_ON       = 8'hA5;
	localparam logic [7:0] OP_NORMAL       = 8'hA6;
	localparam logic [7:0] OP_INVERSE      = 8'hA7;
	localparam logic [7:0] OP_PARTIAL_ON   = 8'hA8;
	localparam logic [7:0] OP_PARTIAL_OFF  = 8'hA9;
	localparam logic [7:0] OP_FUNC_SEL     = 8'hAB;
	localparam logic [7:0] OP_OFF          = 8'hAE;
	localparam logic [7:0] OP_ON           = 8'hAF;
	localparam logic [7:0] OP_PHASE        = 8'hB1;
	localparam logic [7:0] OP_CLOCK_DIV    = 8'hB3;
	localparam logic [7:0] OP_VSL          = 8'hB4;
	localparam logic [7:0] OP_GPIO         = 8'hB5;
	localparam logic [7:0] OP_PRECHARGE2   = 8'hB6;
	localparam logic [7:0] OP_GRAY_TABLE   = 8'hB8;
	localparam logic [7:0] OP_GRAY_DEFAULT = 8'hB9;
	localparam logic [7:0] OP_PRECHARGE_V  = 8'hBB;
	localparam logic [7:0] OP_VCOMH        = 8'hBE;
	localparam logic [7:0] OP_CONTRAST     = 8'hC1;
	localparam logic [7:0] OP_MASTER_CUR   = 8'hC7;
	localparam logic [7:0] OP_MUX_RATIO    = 8'hCA;
	localparam logic [7:0] OP_ENHANCE      = 8'hD1;
	localparam logic [7:0] OP_LOCK         = 8'hFD;

	localparam logic [7:0] LOCK_CODE   = 8'h16;
	localparam logic [7:0] UNLOCK_CODE = 8'h12;

	localparam logic KIND_COMMAND = 1'b0;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
	} ocsd_in_t;

	typedef struct packed {
		logic       ram_write;
		logic [6:0] ram_row;
		logic [6:0] ram_column;
		logic       ram_half;
		logic [7:0] ram_data;
		logic       setting_write;
		logic [7:0] setting_command;
		logic [3:0] setting_index;
		logic       dropped;
		logic       display_on;
		logic       locked;
	} ocsd_out_t;

	typedef struct packed {
		logic                   known;
		logic [PARAM_CNT_W-1:0] count;
	} ocsd_pcnt_t;

	typedef struct packed {
		logic       advance;
		logic       col_start;
		logic       col_end;
		logic       row_start;
		logic       row_end;
		logic       remap_set;
		logic [7:0] value;
	} ocsd_addr_ctl_t;

	typedef struct packed {
		logic [6:0] row;
		logic [6:0] col;
		logic       half;
	} ocsd_ptr_t;

	function automatic ocsd_pcnt_t param_count(input logic [7:0] op,
		input logic [PARAM_CNT_W-1:0] max_params);
		ocsd_pcnt_t r;
		r.known = 1'b1;
		r.count = '0;
		case (op)
			OP_GRAY_ENABLE, OP_WRITE_RAM, OP_ALL_OFF, OP_ALL_ON, OP_NORMAL,
			OP_INVERSE, OP_PARTIAL_OFF, OP_OFF, OP_ON, OP_GRAY_DEFAULT: begin
				r.count = PARAM_CNT_W'(0);
			end
			OP_START_LINE, OP_OFFSET, OP_FUNC_SEL, OP_PHASE, OP_CLOCK_DIV,
			OP_GPIO, OP_PRECHARGE2, OP_PRECHARGE_V, OP_VCOMH, OP_CONTRAST,
			OP_MASTER_CUR, OP_MUX_RATIO, OP_LOCK: begin
				r.count = PARAM_CNT_W'(1);
			end
			OP_COLUMN, OP_ROW, OP_REMAP, OP_PARTIAL_ON, OP_VSL, OP_ENHANCE: begin
				r.count = PARAM_CNT_W'(2);
			end
			OP_GRAY_TABLE: begin
				r.count = max_params;
			end
			default: begin
				r.known = 1'b0;
			end
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/ocsd_chan_if.sv -----
// ----------------------------------------------------------------------------
// OLED command stream decoder channel
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface ocsd_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ocsd_addr.sv -----
// ----------------------------------------------------------------------------
// OLED command stream decoder address unit
// Holds the write window and the memory pointers and steps the pointers per data word.
// ----------------------------------------------------------------------------
`include "oled_command_stream_decoder_assert.svh"

module ocsd_addr #(
	parameter int COLUMNS = ocsd_pkg::DEF_COLUMNS,
	parameter int ROWS    = ocsd_pkg::DEF_ROWS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ocsd_pkg::ocsd_addr_ctl_t ctl,
	output ocsd_pkg::ocsd_ptr_t      ptr
);
	import ocsd_pkg::*;

	localparam logic [7:0] COL_MAX = 8'(COLUMNS - 1);
	localparam logic [7:0] ROW_MAX = 8'(ROWS - 1);

	logic [6:0] col_first_q, col_last_q, row_first_q, row_last_q;
	logic [6:0] col_ptr_q, row_ptr_q;
	logic       half_q;
	logic       vert_q;
	logic [6:0] col_clamp, row_clamp;
	logic       col_wrap, row_wrap;
	logic [6:0] col_step, row_step;
	logic [6:0] col_adv, row_adv;

	always_comb begin
		col_clamp = (ctl.value > COL_MAX) ? COL_MAX[6:0] : ctl.value[6:0];
		row_clamp = (ctl.value > ROW_MAX) ? ROW_MAX[6:0] : ctl.value[6:0];
		col_wrap  = col_ptr_q >= col_last_q;
		row_wrap  = row_ptr_q >= row_last_q;
		col_step  = col_wrap ? col_first_q : 7'(col_ptr_q + 7'd1);
		row_step  = row_wrap ? row_first_q : 7'(row_ptr_q + 7'd1);
		col_adv   = col_ptr_q;
		row_adv   = row_ptr_q;
		if (half_q) begin
			if (vert_q) begin
				row_adv = row_step;
				if (row_wrap) begin
					col_adv = col_step;
				end
			end else begin
				col_adv = col_step;
				if (col_wrap) begin
					row_adv = row_step;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_first_q <= '0;
			col_last_q  <= COL_MAX[6:0];
			row_first_q <= '0;
			row_last_q  <= ROW_MAX[6:0];
			col_ptr_q   <= '0;
			row_ptr_q   <= '0;
			half_q      <= 1'b0;
			vert_q      <= 1'b0;
		end else begin
			if (ctl.advance) begin
				half_q    <= !half_q;
				col_ptr_q <= col_adv;
				row_ptr_q <= row_adv;
			end
			if (ctl.col_start) begin
				col_first_q <= col_clamp;
				col_ptr_q   <= col_clamp;
				half_q      <= 1'b0;
			end
			if (ctl.col_end) begin
				col_last_q <= col_clamp;
			end
			if (ctl.row_start) begin
				row_first_q <= row_clamp;
				row_ptr_q   <= row_clamp;
			end
			if (ctl.row_end) begin
				row_last_q <= row_clamp;
			end
			if (ctl.remap_set) begin
				vert_q <= ctl.value[0];
			end
		end
	end

	assign ptr.row  = row_ptr_q;
	assign ptr.col  = col_ptr_q;
	assign ptr.half = half_q;

	`OCSD_ASSERT_SAME(a_col_in_range, 1'b1, {1'b0, col_ptr_q} <= COL_MAX, "column pointer out of range")
	`OCSD_ASSERT_SAME(a_row_in_range, 1'b1, {1'b0, row_ptr_q} <= ROW_MAX, "row pointer out of range")
	`OCSD_ASSERT_NEXT(a_ptr_hold, !ctl.advance && !ctl.col_start && !ctl.row_start, $stable(col_ptr_q) && $stable(row_ptr_q) && $stable(half_q), "pointers moved without a cause")

endmodule

// ----- rtl/core/ocsd_decode.sv -----
// ----------------------------------------------------------------------------
// OLED command stream decoder command tracker
// Tracks the current command, parameter position, lock and display state,
// and forms the result word for one input word.
// ----------------------------------------------------------------------------
module ocsd_decode #(
	parameter int MAX_PARAMS = ocsd_pkg::DEF_MAX_PARAMS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  ocsd_pkg::ocsd_in_t       item,
	input  ocsd_pkg::ocsd_ptr_t      ptr,
	output ocsd_pkg::ocsd_out_t      res,
	output ocsd_pkg::ocsd_addr_ctl_t ctl
);
	import ocsd_pkg::*;

	localparam logic [PARAM_CNT_W-1:0] MAX_CNT = PARAM_CNT_W'(MAX_PARAMS);

	logic [7:0]             cmd_q, cmd_d;
	logic [PARAM_CNT_W-1:0] pos_q, pos_d;
	logic                   stream_q, stream_d;
	logic                   lock_q, lock_d;
	logic                   panel_q, panel_d;
	ocsd_pcnt_t             cur_cnt, new_cnt;
	logic                   lock_param;
	logic                   first_pos, second_pos;

	always_comb begin
		cur_cnt    = param_count(cmd_q, MAX_CNT);
		new_cnt    = param_count(item.value, MAX_CNT);
		lock_param = (cmd_q == OP_LOCK) && (pos_q == '0);
		first_pos  = pos_q == PARAM_CNT_W'(0);
		second_pos = pos_q == PARAM_CNT_W'(1);
		cmd_d      = cmd_q;
		pos_d      = pos_q;
		stream_d   = stream_q;
		lock_d     = lock_q;
		panel_d    = panel_q;
		res        = '0;
		ctl        = '0;
		ctl.value  = item.value;
		if (item.kind == KIND_COMMAND) begin
			if (lock_q && (item.value != OP_LOCK)) begin
				res.dropped = 1'b1;
			end else begin
				cmd_d    = item.value;
				pos_d    = '0;
				stream_d = item.value == OP_WRITE_RAM;
				if (item.value == OP_OFF) begin
					panel_d = 1'b0;
				end else if (item.value == OP_ON) begin
					panel_d = 1'b1;
				end
				res.dropped = !new_cnt.known;
			end
		end else begin
			if (lock_q && !lock_param) begin
				res.dropped = 1'b1;
			end else if (stream_q) begin
				res.ram_write  = 1'b1;
				res.ram_row    = ptr.row;
				res.ram_column = ptr.col;
				res.ram_half   = ptr.half;
				res.ram_data   = item.value;
				ctl.advance    = en;
			end else if ((cur_cnt.count != '0) && (pos_q < cur_cnt.count)) begin
				res.setting_write   = 1'b1;
				res.setting_command = cmd_q;
				res.setting_index   = pos_q[3:0];
				ctl.col_start = en && (cmd_q == OP_COLUMN) && first_pos;
				ctl.col_end   = en && (cmd_q == OP_COLUMN) && second_pos;
				ctl.row_start = en && (cmd_q == OP_ROW) && first_pos;
				ctl.row_end   = en && (cmd_q == OP_ROW) && second_pos;
				ctl.remap_set = en && (cmd_q == OP_REMAP) && first_pos;
				if (cmd_q == OP_LOCK) begin
					if (item.value == LOCK_CODE) begin
						lock_d = 1'b1;
					end else if (item.value == UNLOCK_CODE) begin
						lock_d = 1'b0;
					end
				end
				pos_d = PARAM_CNT_W'(pos_q + 1'b1);
			end else begin
				res.dropped = 1'b1;
			end
		end
		res.display_on = panel_d;
		res.locked     = lock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= OP_GRAY_ENABLE;
			pos_q    <= '0;
			stream_q <= 1'b0;
			lock_q   <= 1'b0;
			panel_q  <= 1'b0;
		end else if (en) begin
			cmd_q    <= cmd_d;
			pos_q    <= pos_d;
			stream_q <= stream_d;
			lock_q   <= lock_d;
			panel_q  <= panel_d;
		end
	end

endmodule

// ----- rtl/core/oled_command_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// OLED command stream decoder
// Receive side of the display controller: decodes tagged command and data
// words into display memory writes and command parameter reports.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word is held in the input stage, then its result word in the result stage.
// Throughput: one word per cycle; a stalled result holds the input stage, so
// the input takes at most one more word before its ready drops.
// Reset: arst_n clears both stage valids, the command state, the window
// (full panel), the pointers, the lock and the display state at once.
`include "oled_command_stream_decoder_assert.svh"

module oled_command_stream_decoder #(
	parameter int COLUMNS    = ocsd_pkg::DEF_COLUMNS,
	parameter int ROWS       = ocsd_pkg::DEF_ROWS,
	parameter int MAX_PARAMS = ocsd_pkg::DEF_MAX_PARAMS
) (
	input logic        clk,
	input logic        arst_n,
	ocsd_chan_if.sink   byte_ch,
	ocsd_chan_if.source result_ch
);
	import ocsd_pkg::*;

	ocsd_in_t       item_s1;
	logic           item_vld_s1;
	ocsd_out_t      res_s2;
	logic           res_vld_s2;
	ocsd_out_t      res;
	ocsd_addr_ctl_t ctl;
	ocsd_ptr_t      ptr;
	logic           adv;
	logic           fire;
	logic           take;

	assign adv           = !res_vld_s2 || result_ch.ready;
	assign fire          = item_vld_s1 && adv;
	assign byte_ch.ready = !item_vld_s1 || adv;
	assign take          = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			res_vld_s2  <= 1'b0;
		end else begin
			if (take) begin
				item_vld_s1 <= 1'b1;
			end else if (adv) begin
				item_vld_s1 <= 1'b0;
			end
			if (adv) begin
				res_vld_s2 <= item_vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= byte_ch.data;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	ocsd_decode #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_decode (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (fire),
		.item  (item_s1),
		.ptr   (ptr),
		.res   (res),
		.ctl   (ctl)
	);

	ocsd_addr #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_addr (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.ptr   (ptr)
	);

	assign result_ch.valid = res_vld_s2;
	assign result_ch.data  = res_s2;

	`OCSD_ASSERT_SAME(a_kind_excl, res_vld_s2 && res_s2.ram_write, !res_s2.setting_write && !res_s2.dropped, "memory write also flagged as setting or dropped")
	`OCSD_ASSERT_NEXT(a_s1_hold, item_vld_s1 && !adv, item_vld_s1, "stalled word lost from the input stage")
	`OCSD_ASSERT_NEXT(a_s1_to_s2, fire, res_vld_s2, "decoded word did not reach the result stage")

endmodule
